[hdl/mthw_pkg.sv]
// Shared types and constants for the multi-task heartbeat watchdog.
`default_nettype none

package mthw_pkg;

    localparam int TASKS    = 8;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int MASK_W   = 8;
    localparam int TID_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Compare width wide enough for any task number and any task_id.
    localparam int TCMP_W = (TASKS > 16) ? 6 : 5;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd4;

    localparam logic [MASK_W-1:0] EXPECTED_RST = '0;
    localparam logic [MS_W-1:0]   GRACE_RST    = 16'd15000;
    localparam logic [MS_W-1:0]   STALE_RST    = 16'd10000;
    localparam logic [MS_W-1:0]   TIMEOUT_RST  = 16'd30000;
    localparam logic [MS_W-1:0]   PERIOD_RST   = 16'd1000;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_BEAT  = 2'd1,
        KIND_START = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [TID_W-1:0] task_id;
    } in_item_t;

    typedef struct packed {
        logic              reset_out;
        logic              reloaded;
        logic              check_failed;
        logic [MASK_W-1:0] problem_mask;
        logic              armed;
    } out_item_t;

    // Per-cycle commands from the sequencer to one task cell.
    typedef struct packed {
        logic beat;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/mthw_cell.sv]
// One task cell: heartbeat stamp, seen bit and age check, chained health flag.
`default_nettype none

module mthw_cell
    import mthw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctl_t         ctl,
    input  wire logic [TIME_W-1:0] now_cur,
    input  wire logic [TIME_W-1:0] now_chk,
    input  wire logic [MS_W-1:0]   stale,
    input  wire logic              expected,
    input  wire logic              bad_in,
    output logic                   bad,
    output logic                   bad_out
);

    logic              seen_reg;
    logic              seen_next;
    logic [TIME_W-1:0] beat_reg;
    logic [TIME_W-1:0] age;

    always_comb
    begin
        seen_next = seen_reg;
        if (ctl.clear)
        begin
            seen_next = 1'b0;
        end
        else if (ctl.beat)
        begin
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // Stamp is only read while the seen bit is set, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.beat)
        begin
            beat_reg <= now_cur;
        end
    end

    assign age     = now_chk - beat_reg;
    assign bad     = expected & (~seen_reg | (age > {{(TIME_W-MS_W){1'b0}}, stale}));
    assign bad_out = bad_in | bad;

endmodule

`default_nettype wire

[hdl/multi_task_heartbeat_watchdog.sv]
// Each transfer is processed as it is accepted; its result sits in the output register next cycle.
// One item per cycle while the output side takes results, and the input stalls only while a
// result waits in the output register.
// The health check is a chain of task cells feeding a wired OR of problem flags.
// rst_n clears the clock, the supervision state and the output valid flag and loads the
// register defaults; a watchdog expiry returns all but the output register to that same state.
`default_nettype none

module multi_task_heartbeat_watchdog
    import mthw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MASK_W-1:0] expected_reg, expected_next;
    logic [MS_W-1:0]   grace_reg, grace_next;
    logic [MS_W-1:0]   stale_reg, stale_next;
    logic [MS_W-1:0]   timeout_reg, timeout_next;
    logic [MS_W-1:0]   period_reg, period_next;

    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] nowp1_reg, nowp1_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              started_reg, started_next;
    logic [MS_W-1:0]   div_reg, div_next;
    logic [MS_W-1:0]   wdt_reg, wdt_next;
    logic [TASKS-1:0]  prob_reg, prob_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              accept;
    logic              beat_ok;
    logic              expire;
    logic              start_go;
    logic [MS_W-1:0]   div_inc;
    logic              in_grace;
    logic [TIME_W-1:0] since_start;
    logic [TASKS-1:0]  exp_vec;
    logic [TASKS-1:0]  bad_vec;
    logic [TASKS:0]    chain;
    logic              rel, fail;
    logic [TCMP_W-1:0] tid_ext;

    assign accept   = in_valid & ~in_stall;
    assign in_stall = out_valid_reg & out_stall;
    assign exp_vec  = TASKS'(expected_reg);
    assign tid_ext  = TCMP_W'(in_data.task_id);
    assign beat_ok  = accept && (in_data.kind == KIND_BEAT) && (tid_ext < TCMP_W'(TASKS));
    assign start_go = accept && (in_data.kind == KIND_START) && !started_reg;

    assign since_start = nowp1_reg - start_reg;
    assign in_grace    = since_start < {{(TIME_W-MS_W){1'b0}}, grace_reg};
    assign div_inc     = div_reg + 1'b1;

    assign chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TASKS; gi++)
        begin : g_cell
            cell_ctl_t cell_ctl;

            assign cell_ctl.beat  = beat_ok && (tid_ext == TCMP_W'(gi));
            assign cell_ctl.clear = start_go | expire;

            mthw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .now_cur  (now_reg),
                .now_chk  (nowp1_reg),
                .stale    (stale_reg),
                .expected (exp_vec[gi]),
                .bad_in   (chain[gi]),
                .bad      (bad_vec[gi]),
                .bad_out  (chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        expected_next = expected_reg;
        grace_next    = grace_reg;
        stale_next    = stale_reg;
        timeout_next  = timeout_reg;
        period_next   = period_reg;
        now_next      = now_reg;
        nowp1_next    = nowp1_reg;
        start_next    = start_reg;
        started_next  = started_reg;
        div_next      = div_reg;
        wdt_next      = wdt_reg;
        prob_next     = prob_reg;
        rel           = 1'b0;
        fail          = 1'b0;
        expire        = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPECTED: expected_next = cfg_data[MASK_W-1:0];
                CFG_GRACE:    grace_next    = cfg_data;
                CFG_STALE:    stale_next    = cfg_data;
                CFG_TIMEOUT:  timeout_next  = cfg_data;
                CFG_PERIOD:   period_next   = cfg_data;
                default:      ;
            endcase
        end

        if (accept)
        begin
            unique case (in_data.kind)
                KIND_TICK:
                begin
                    now_next   = nowp1_reg;
                    nowp1_next = nowp1_reg + 1'b1;
                    if (started_reg)
                    begin
                        div_next = div_inc;
                        if (div_inc >= period_reg)
                        begin
                            div_next  = '0;
                            prob_next = in_grace ? '0 : bad_vec;
                            if (in_grace || !chain[TASKS])
                            begin
                                wdt_next = timeout_reg;
                                rel      = 1'b1;
                            end
                            else
                            begin
                                fail = 1'b1;
                            end
                        end
                        if (!rel)
                        begin
                            if (wdt_reg <= MS_W'(1))
                            begin
                                expire = 1'b1;
                            end
                            else
                            begin
                                wdt_next = wdt_reg - 1'b1;
                            end
                        end
                    end
                end
                KIND_BEAT: ;
                KIND_START:
                begin
                    if (!started_reg)
                    begin
                        start_next   = now_reg;
                        wdt_next     = timeout_reg;
                        div_next     = '0;
                        started_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Expiry drops the registers and the supervision state back to the power-on state.
        if (expire)
        begin
            expected_next = EXPECTED_RST;
            grace_next    = GRACE_RST;
            stale_next    = STALE_RST;
            timeout_next  = TIMEOUT_RST;
            period_next   = PERIOD_RST;
            now_next      = '0;
            nowp1_next    = TIME_W'(1);
            start_next    = '0;
            started_next  = 1'b0;
            div_next      = '0;
            wdt_next      = '0;
            prob_next     = '0;
            fail          = 1'b0;
        end

        out_valid_next = out_valid_reg & out_stall;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next             = 1'b1;
            out_data_next.reset_out    = expire;
            out_data_next.reloaded     = rel;
            out_data_next.check_failed = fail;
            out_data_next.problem_mask = MASK_W'(prob_next);
            out_data_next.armed        = started_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= EXPECTED_RST;
            grace_reg     <= GRACE_RST;
            stale_reg     <= STALE_RST;
            timeout_reg   <= TIMEOUT_RST;
            period_reg    <= PERIOD_RST;
            now_reg       <= '0;
            nowp1_reg     <= TIME_W'(1);
            start_reg     <= '0;
            started_reg   <= 1'b0;
            div_reg       <= '0;
            wdt_reg       <= '0;
            prob_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            grace_reg     <= grace_next;
            stale_reg     <= stale_next;
            timeout_reg   <= timeout_next;
            period_reg    <= period_next;
            now_reg       <= now_next;
            nowp1_reg     <= nowp1_next;
            start_reg     <= start_next;
            started_reg   <= started_next;
            div_reg       <= div_next;
            wdt_reg       <= wdt_next;
            prob_reg      <= prob_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
